### hw/rtl/tmb_pkg.sv
package tmb_pkg;

  localparam int unsigned SAMPLES_DEF     = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 8;

  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned MEAN_W    = 40;
  localparam int unsigned DISC_W    = 6;
  localparam int unsigned TRIM_W    = 5;
  localparam int unsigned CFG_W     = 6;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DISCARD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM    = 1'b1;

  typedef struct packed {
    logic write;
    logic init;
    logic fetch;
    logic latch;
    logic scan;
    logic decide;
    logic div_step;
  } tmb_cmd_t;

  typedef struct packed {
    logic load_last;
    logic bad;
    logic scan_last;
    logic i_last;
    logic div_last;
  } tmb_stat_t;

endpackage

### hw/rtl/tmb_ram.sv
module tmb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/tmb_datapath.sv
module tmb_datapath import tmb_pkg::*; #(
  parameter int unsigned SAMPLES     = SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tmb_cmd_t             cmd_i,
  output tmb_stat_t            stat_o,
  input  logic [SAMPLE_W-1:0]  sample_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output logic [MEAN_W-1:0]    mean_o,
  output logic                 bad_setting_o
);

  localparam int unsigned IDX_W = $clog2(SAMPLES);
  localparam int unsigned CNT_W = $clog2(SAMPLES + 1);
  localparam int unsigned CMP_W = (CNT_W > 7) ? CNT_W : 7;
  localparam int unsigned SUM_W = SAMPLE_BITS + CNT_W;
  localparam int unsigned DIV_W = SUM_W + FRAC_BITS;
  localparam int unsigned DC_W  = $clog2(DIV_W);

  logic [DISC_W-1:0]      disc_q;
  logic [TRIM_W-1:0]      trim_q;
  logic [IDX_W-1:0]       wr_ptr_q, i_q, j_q, jd_q;
  logic [CNT_W-1:0]       rank_q;
  logic                   cmp_v_q;
  logic                   bad_q;
  logic [DC_W-1:0]        div_cnt_q;
  logic [SAMPLE_BITS-1:0] vi_q;
  logic [SUM_W-1:0]       sum_q;
  logic [DIV_W-1:0]       quo_q;
  logic [CNT_W-1:0]       rem_q;

  logic [SAMPLE_BITS-1:0] rdata;
  logic [IDX_W-1:0]       raddr;
  logic [CMP_W-1:0]       drop;
  logic [CNT_W-1:0]       keep_hi, count;
  logic                   less, keep;
  logic [SUM_W-1:0]       sum_d;
  logic [CNT_W:0]         r2;
  logic                   q_bit;

  assign raddr = cmd_i.fetch ? i_q : j_q;

  tmb_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(SAMPLES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.write),
    .waddr_i(wr_ptr_q),
    .wdata_i(SAMPLE_BITS'(sample_i)),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign drop    = CMP_W'(disc_q) + (CMP_W'(trim_q) << 1);
  assign keep_hi = CNT_W'(SAMPLES) - CNT_W'(disc_q) - CNT_W'(trim_q);
  assign count   = keep_hi - CNT_W'(trim_q);

  assign less  = (rdata < vi_q) || ((rdata == vi_q) && (jd_q < i_q));
  assign keep  = (rank_q >= CNT_W'(trim_q)) && (rank_q < keep_hi);
  assign sum_d = keep ? (sum_q + SUM_W'(vi_q)) : sum_q;

  assign r2    = {rem_q, quo_q[DIV_W-1]};
  assign q_bit = r2 >= {1'b0, count};

  assign stat_o.load_last = wr_ptr_q == IDX_W'(SAMPLES - 1);
  assign stat_o.bad       = drop >= CMP_W'(SAMPLES);
  assign stat_o.scan_last = j_q == IDX_W'(SAMPLES - 1);
  assign stat_o.i_last    = i_q == IDX_W'(SAMPLES - 1);
  assign stat_o.div_last  = div_cnt_q == DC_W'(DIV_W - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disc_q    <= '0;
      trim_q    <= '0;
      wr_ptr_q  <= '0;
      i_q       <= '0;
      j_q       <= '0;
      rank_q    <= '0;
      cmp_v_q   <= 1'b0;
      bad_q     <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DISCARD: disc_q <= cfg_wdata_i[DISC_W-1:0];
          REG_TRIM:    trim_q <= cfg_wdata_i[TRIM_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.write) begin
        wr_ptr_q <= stat_o.load_last ? '0 : wr_ptr_q + 1'b1;
      end
      if (cmd_i.init) begin
        i_q   <= IDX_W'(disc_q);
        bad_q <= stat_o.bad;
      end
      if (cmd_i.decide) begin
        i_q <= i_q + 1'b1;
      end
      if (cmd_i.latch) begin
        j_q    <= IDX_W'(disc_q);
        rank_q <= '0;
      end else if (cmp_v_q && less) begin
        rank_q <= rank_q + 1'b1;
      end
      if (cmd_i.scan) begin
        j_q <= j_q + 1'b1;
      end
      cmp_v_q <= cmd_i.scan;
      if (cmd_i.decide) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    jd_q <= j_q;
    if (cmd_i.init) begin
      sum_q <= '0;
      quo_q <= '0;
    end
    if (cmd_i.latch) begin
      vi_q <= rdata;
    end
    if (cmd_i.decide) begin
      sum_q <= sum_d;
      if (stat_o.i_last) begin
        quo_q <= DIV_W'(sum_d) << FRAC_BITS;
        rem_q <= '0;
      end
    end
    if (cmd_i.div_step) begin
      quo_q <= {quo_q[DIV_W-2:0], q_bit};
      rem_q <= q_bit ? CNT_W'(r2 - {1'b0, count}) : r2[CNT_W-1:0];
    end
  end

  assign mean_o        = MEAN_W'(quo_q);
  assign bad_setting_o = bad_q;

endmodule

### hw/rtl/tmb_ctrl.sv
module tmb_ctrl import tmb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  tmb_stat_t stat_i,
  output tmb_cmd_t  cmd_o,
  output logic      busy_o,
  output logic      done_o
);

  typedef enum logic [8:0] {
    ST_LOAD   = 9'b000000001,
    ST_INIT   = 9'b000000010,
    ST_FETCH  = 9'b000000100,
    ST_LATCH  = 9'b000001000,
    ST_SCAN   = 9'b000010000,
    ST_DRAIN  = 9'b000100000,
    ST_DECIDE = 9'b001000000,
    ST_DIV    = 9'b010000000,
    ST_DONE   = 9'b100000000
  } tmb_state_e;

  tmb_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_LOAD: begin
        if (start_i) begin
          cmd_o.write = 1'b1;
          if (stat_i.load_last) begin
            state_d = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = stat_i.bad ? ST_DONE : ST_FETCH;
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = ST_LATCH;
      end
      ST_LATCH: begin
        cmd_o.latch = 1'b1;
        state_d     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = stat_i.i_last ? ST_DIV : ST_FETCH;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_LOAD;
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != ST_LOAD;
  assign done_o = state_q == ST_DONE;

endmodule

### hw/rtl/trimmed_mean_of_batch_top.sv
// channel   ports                                  handshake
// sample    sample_i                               start && !busy
// result    mean_o, bad_setting_o                  done_o, one cycle
// config    cfg_idx_i, cfg_wdata_i                 cfg_we_i
//
// samples load one per cycle; busy stays low until the last sample of a batch
// after the last sample, n = SAMPLES - discard_count samples go through a rank scan
// through the single read port of the sample memory, then bit-serial division
// a bad setting skips both: after the last beat the init state goes straight to done
// reset is asynchronous, active low; the result receiver cannot stall
module trimmed_mean_of_batch_top import tmb_pkg::*; #(
  parameter int unsigned SAMPLES     = SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [SAMPLE_W-1:0]  sample_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                 done_o,
  output logic [MEAN_W-1:0]    mean_o,
  output logic                 bad_setting_o
);

  tmb_cmd_t  cmd;
  tmb_stat_t stat;

  tmb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  tmb_datapath #(
    .SAMPLES    (SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .sample_i     (sample_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mean_o       (mean_o),
    .bad_setting_o(bad_setting_o)
  );

`ifndef ASSERT_OFF
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result strobe not a single cycle");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && bad_setting_o |-> mean_o == '0)
    else $error("bad setting with nonzero mean");

  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(done_o))
    else $error("busy dropped without a result");
`endif

endmodule
